// ----- rtl/sct_pkg.sv -----
// Package: constants and types shared by the countdown task scheduler.
package sct_pkg;
  localparam int TaskSlots = 8;
  localparam int SlotW = $clog2(TaskSlots);
  localparam int LinkW = SlotW + 1;
  localparam int CntW = $clog2(TaskSlots + 1);
  localparam logic [LinkW-1:0] NilLink = LinkW'(TaskSlots);

  localparam logic CmdAdd = 1'b0;
  localparam logic CmdProc = 1'b1;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
  } cmp_in_t;

  typedef struct packed {
    logic        lt;
    logic        le;
    logic        gt;
    logic [15:0] sat_sub;
  } cmp_out_t;
endpackage

// ----- rtl/sct_alu.sv -----
// Shared compare and saturating subtract unit.
module sct_alu
  import sct_pkg::*;
(
  input  cmp_in_t  op_i,
  output cmp_out_t res_o
);
  assign res_o.lt = op_i.a < op_i.b;
  assign res_o.le = op_i.a <= op_i.b;
  assign res_o.gt = op_i.a > op_i.b;
  assign res_o.sat_sub = (op_i.b > op_i.a) ? 16'd0 : (op_i.a - op_i.b);
endmodule

// ----- rtl/sorted_countdown_task_scheduler.sv -----
// Top level: task slot pool, ordered queue walker and sequencer.
//  channel | ports                                                | dir
//  command | start, cmd_i, callback_id_i, period_i,               | in
//          | min_service_time_i, delay_i, elapsed_ticks_i         |
//  result  | busy, done_o, status_o, fired_o, fired_callback_id_o | out
// An add or a process walks the queue one node per cycle through the
// shared compare/subtract unit.
// Reset empties the queue and refills the free stack at once.
// Results show for one cycle on done_o; the receiver cannot stall.
module sorted_countdown_task_scheduler
  import sct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [7:0]  callback_id_i,
  input  logic [15:0] period_i,
  input  logic [15:0] min_service_time_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] elapsed_ticks_i,
  output logic        done_o,
  output logic        status_o,
  output logic        fired_o,
  output logic [7:0]  fired_callback_id_o
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_AHEAD = 7'b0000010,
    S_AWALK = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_FIRE  = 7'b0010000,
    S_RWALK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] timer_q [TaskSlots];
  logic [15:0] period_q [TaskSlots];
  logic [7:0]  action_q [TaskSlots];
  logic        recur_q [TaskSlots];
  logic [LinkW-1:0] link_q [TaskSlots];
  logic [SlotW-1:0] fstack_q [TaskSlots];
  logic [LinkW-1:0] first_q;
  logic [CntW-1:0]  fcount_q;

  logic [15:0] mst_q, dly_q, elp_q;
  logic [SlotW-1:0] new_q;
  logic [LinkW-1:0] cur_q;
  logic [SlotW-1:0] prev_q;
  logic [CntW-1:0]  guard_q;
  logic status_q, fired_q;
  logic [7:0] fid_q;

  cmp_in_t  cin;
  cmp_out_t cres;

  sct_alu u_alu (.op_i(cin), .res_o(cres));

  logic [SlotW-1:0] cur_s, first_s, nx_s;
  logic [LinkW-1:0] nx;
  logic cur_ok, nx_ok;
  assign cur_s   = cur_q[SlotW-1:0];
  assign cur_ok  = (cur_q < NilLink);
  assign first_s = first_q[SlotW-1:0];
  assign nx      = link_q[prev_q];
  assign nx_ok   = (nx < NilLink);
  assign nx_s    = nx[SlotW-1:0];

  always_comb begin
    cin.a = timer_q[nx_s];
    cin.b = mst_q;
    case (state_q)
      S_AHEAD: begin
        cin.a = timer_q[first_s];
        cin.b = mst_q;
      end
      S_AWALK: begin
        cin.a = timer_q[nx_s];
        cin.b = mst_q;
      end
      S_DEC: begin
        cin.a = timer_q[cur_s];
        cin.b = elp_q;
      end
      S_RWALK: begin
        cin.a = timer_q[nx_s];
        cin.b = timer_q[first_s];
      end
      default: ;
    endcase
  end

  logic a_head_more, a_walk_go;
  assign a_head_more = cres.gt && (timer_q[first_s] > dly_q);
  assign a_walk_go = nx_ok && cres.lt && ((dly_q == 16'd0) || (timer_q[nx_s] <= dly_q));

  assign busy = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign status_o = status_q;
  assign fired_o = fired_q;
  assign fired_callback_id_o = fid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) begin
        if (cmd_i == CmdProc) begin
          state_d = S_DEC;
        end else if (fcount_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_AHEAD;
        end
      end
      S_AHEAD: state_d = (first_q >= NilLink || a_head_more) ? S_DONE : S_AWALK;
      S_AWALK: if (!a_walk_go || guard_q == CntW'(TaskSlots - 1)) state_d = S_DONE;
      S_DEC:   if (!cur_ok || elp_q == 16'd0 || guard_q == CntW'(TaskSlots - 1)) begin
        state_d = S_FIRE;
      end
      S_FIRE:  state_d = (first_q < NilLink && timer_q[first_s] == 16'd0 &&
                          recur_q[first_s]) ? S_RWALK : S_DONE;
      S_RWALK: if (!(nx_ok && cres.le) || guard_q == CntW'(TaskSlots - 1)) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      first_q  <= NilLink;
      fcount_q <= CntW'(TaskSlots);
      for (int i = 0; i < TaskSlots; i++) fstack_q[i] <= SlotW'(i);
      status_q <= 1'b0;
      fired_q  <= 1'b0;
      fid_q    <= '0;
      guard_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: if (start) begin
          status_q <= (cmd_i == CmdAdd) && (fcount_q == '0);
          fired_q  <= 1'b0;
          fid_q    <= '0;
          guard_q  <= '0;
          mst_q    <= min_service_time_i;
          dly_q    <= delay_i;
          elp_q    <= elapsed_ticks_i;
          cur_q    <= first_q;
          if (cmd_i == CmdAdd) begin
            if (fcount_q != '0) begin
              new_q <= fstack_q[SlotW'(CntW'(TaskSlots) - fcount_q)];
              fcount_q <= fcount_q - 1'b1;
              recur_q[fstack_q[SlotW'(CntW'(TaskSlots) - fcount_q)]] <= (period_i != 16'd0);
              action_q[fstack_q[SlotW'(CntW'(TaskSlots) - fcount_q)]] <= callback_id_i;
              period_q[fstack_q[SlotW'(CntW'(TaskSlots) - fcount_q)]] <= period_i;
              timer_q[fstack_q[SlotW'(CntW'(TaskSlots) - fcount_q)]] <= delay_i;
            end
          end
        end
        S_AHEAD: begin
          prev_q <= first_s;
          if (first_q >= NilLink || a_head_more) begin
            link_q[new_q] <= first_q;
            first_q <= LinkW'(new_q);
          end
        end
        S_AWALK: begin
          if (!a_walk_go || guard_q == CntW'(TaskSlots - 1)) begin
            link_q[new_q]  <= nx;
            link_q[prev_q] <= LinkW'(new_q);
          end else begin
            prev_q  <= nx_s;
            guard_q <= guard_q + 1'b1;
          end
        end
        S_DEC: begin
          if (cur_ok && elp_q != 16'd0) begin
            timer_q[cur_s] <= cres.sat_sub;
            cur_q <= link_q[cur_s];
          end
          guard_q <= guard_q + 1'b1;
        end
        S_FIRE: begin
          guard_q <= '0;
          prev_q  <= first_s;
          if (first_q < NilLink && timer_q[first_s] == 16'd0) begin
            fired_q <= 1'b1;
            fid_q   <= action_q[first_s];
            if (recur_q[first_s]) begin
              timer_q[first_s] <= period_q[first_s];
            end else begin
              if (fcount_q < CntW'(TaskSlots)) begin
                fcount_q <= fcount_q + 1'b1;
                fstack_q[SlotW'(CntW'(TaskSlots) - fcount_q - 1'b1)] <= first_s;
              end
              first_q <= link_q[first_s];
            end
          end
        end
        S_RWALK: begin
          if (!(nx_ok && cres.le) || guard_q == CntW'(TaskSlots - 1)) begin
            if (prev_q != first_s) begin
              first_q <= link_q[first_s];
              link_q[first_s] <= nx;
              link_q[prev_q] <= first_q;
            end
          end else begin
            prev_q  <= nx_s;
            guard_q <= guard_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> !fired_o) else $error("status with fire");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcount_q <= CntW'(TaskSlots)) else $error("free count range");
  a_nofire_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !fired_o |-> fired_callback_id_o == 8'd0) else $error("stray id");
`endif
endmodule
